// File: rtl/core/stps_pkg.sv
`timescale 1ns / 1ps

package stps_pkg;

    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_VALUE_BITS  = 64;

    localparam int REQ_TYPE_W  = 1;
    localparam int SLOT_W      = 10;
    localparam int FIELD_VAL_W = 64;
    localparam int COUNT_W     = 11;

    localparam int S_FIELDS_W = SLOT_W + 2 * FIELD_VAL_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = FIELD_VAL_W + SLOT_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1);

    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_WRITE  = 1'b0,
        REQ_SEARCH = 1'b1
    } req_type_t;

endpackage

// File: rtl/core/sorted_table_predecessor_search_top.sv
`timescale 1ns / 1ps

// predecessor search over a sorted table of signed values
// input channel s_*: write item (tuser 0) stores entry_value at slot_index,
//   search item (tuser 1) looks up the last entry below search_key among
//   slots 0 .. entry_count-1; slot 0 is returned when none lies below
// result channel m_*: one item per search, none per write
// cfg_we / cfg_wdata load entry_count; the user must do so while the block is idle;
//   the block itself does not enforce this
// a search is a binary search, each probe a single read of the table memory,
//   followed by a final read of the found slot
// the next item is accepted in the cycle after a search has loaded its result
// a result waits in the output register while the receiver stalls; the next
//   search runs meanwhile and holds in its last step until that register frees
// reset clears the control state and sets entry_count to 1; table contents
//   are undefined until written

module sorted_table_predecessor_search_top
    import stps_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [COUNT_W-1:0]    cfg_wdata,   // entry_count
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,     // slot_index, entry_value, search_key
    input  logic [REQ_TYPE_W-1:0] s_tuser,     // req_type
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata      // found_value, found_slot
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    logic [COUNT_W-1:0]     entry_count_reg;
    logic                   ram_wr_en;
    logic [ADDR_W-1:0]      ram_wr_addr;
    logic [VALUE_BITS-1:0]  ram_wr_data;
    logic                   ram_rd_en;
    logic [ADDR_W-1:0]      ram_rd_addr;
    logic [VALUE_BITS-1:0]  ram_rd_data;
    logic [FIELD_VAL_W-1:0] found_value;
    logic [SLOT_W-1:0]      found_slot;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= COUNT_RESET;
        end else if (cfg_we) begin
            entry_count_reg <= cfg_wdata;
        end
    end

    stps_search_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_BITS  (VALUE_BITS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .entry_count (entry_count_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .req_type    (s_tuser),
        .slot_index  (s_tdata[SLOT_W-1:0]),
        .entry_value (s_tdata[SLOT_W +: FIELD_VAL_W]),
        .search_key  (s_tdata[SLOT_W + FIELD_VAL_W +: FIELD_VAL_W]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .found_value (found_value),
        .found_slot  (found_slot),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    stps_table_ram #(
        .DEPTH  (TABLE_DEPTH),
        .DATA_W (VALUE_BITS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign m_tdata = {{M_PAD_W{1'b0}}, found_slot, found_value};

endmodule

// File: rtl/core/stps_table_ram.sv
`timescale 1ns / 1ps

module stps_table_ram #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/stps_search_ctrl.sv
`timescale 1ns / 1ps

module stps_search_ctrl
    import stps_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int VALUE_BITS  = DEF_VALUE_BITS,
    parameter int ADDR_W      = $clog2(TABLE_DEPTH),
    parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [COUNT_W-1:0]     entry_count,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [REQ_TYPE_W-1:0]  req_type,
    input  logic [SLOT_W-1:0]      slot_index,
    input  logic [FIELD_VAL_W-1:0] entry_value,
    input  logic [FIELD_VAL_W-1:0] search_key,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [FIELD_VAL_W-1:0] found_value,
    output logic [SLOT_W-1:0]      found_slot,
    output logic                   ram_wr_en,
    output logic [ADDR_W-1:0]      ram_wr_addr,
    output logic [VALUE_BITS-1:0]  ram_wr_data,
    output logic                   ram_rd_en,
    output logic [ADDR_W-1:0]      ram_rd_addr,
    input  logic [VALUE_BITS-1:0]  ram_rd_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_FETCH
    } state_t;

    state_t                  state_reg, state_next;
    logic [ADDR_W-1:0]       lo_reg, lo_next;
    logic [CNT_W-1:0]        hi_reg, hi_next;
    logic [ADDR_W-1:0]       mid_reg, mid_next;
    logic [VALUE_BITS-1:0]   key_reg, key_next;
    logic                    out_valid_reg, out_valid_next;
    logic [FIELD_VAL_W-1:0]  found_value_reg, found_value_next;
    logic [SLOT_W-1:0]       found_slot_reg, found_slot_next;

    logic                    accept;
    logic [CNT_W-1:0]        count_sat;
    logic                    key_less;
    logic [ADDR_W-1:0]       lo_step;
    logic [CNT_W-1:0]        hi_step;
    logic [CNT_W:0]          mid_sum;
    logic signed [FIELD_VAL_W-1:0] rd_ext;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb begin
        if (entry_count == '0) begin
            count_sat = CNT_W'(1);
        end else if (32'(entry_count) > TABLE_DEPTH) begin
            count_sat = CNT_W'(TABLE_DEPTH);
        end else begin
            count_sat = CNT_W'(entry_count);
        end
    end

    assign key_less = $signed(ram_rd_data) < $signed(key_reg);
    assign lo_step  = key_less ? mid_reg : lo_reg;
    assign hi_step  = key_less ? hi_reg : CNT_W'(mid_reg);
    assign mid_sum  = (CNT_W + 1)'(lo_step) + (CNT_W + 1)'(hi_step);
    assign rd_ext   = FIELD_VAL_W'($signed(ram_rd_data));

    always_comb begin
        state_next       = state_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        mid_next         = mid_reg;
        key_next         = key_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        found_value_next = found_value_reg;
        found_slot_next  = found_slot_reg;
        ram_wr_en        = 1'b0;
        ram_wr_addr      = ADDR_W'(slot_index);
        ram_wr_data      = entry_value[VALUE_BITS-1:0];
        ram_rd_en        = 1'b0;
        ram_rd_addr      = mid_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (req_type == REQ_WRITE) begin
                        ram_wr_en = (32'(slot_index) < TABLE_DEPTH);
                    end else begin
                        key_next = search_key[VALUE_BITS-1:0];
                        lo_next  = '0;
                        hi_next  = count_sat;
                        mid_next = ADDR_W'(count_sat >> 1);
                        ram_rd_en = 1'b1;
                        if (count_sat > CNT_W'(1)) begin
                            ram_rd_addr = ADDR_W'(count_sat >> 1);
                            state_next  = ST_PROBE;
                        end else begin
                            ram_rd_addr = '0;
                            state_next  = ST_FETCH;
                        end
                    end
                end
            end
            ST_PROBE: begin
                lo_next   = lo_step;
                hi_next   = hi_step;
                ram_rd_en = 1'b1;
                if (hi_step - CNT_W'(lo_step) > CNT_W'(1)) begin
                    mid_next    = ADDR_W'(mid_sum >> 1);
                    ram_rd_addr = ADDR_W'(mid_sum >> 1);
                end else begin
                    ram_rd_addr = lo_step;
                    state_next  = ST_FETCH;
                end
            end
            ST_FETCH: begin
                if (!out_valid_reg || out_ready) begin
                    out_valid_next   = 1'b1;
                    found_value_next = rd_ext;
                    found_slot_next  = SLOT_W'(lo_reg);
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        lo_reg          <= lo_next;
        hi_reg          <= hi_next;
        mid_reg         <= mid_next;
        key_reg         <= key_next;
        found_value_reg <= found_value_next;
        found_slot_reg  <= found_slot_next;
    end

    assign out_valid   = out_valid_reg;
    assign found_value = found_value_reg;
    assign found_slot  = found_slot_reg;

endmodule

// File: rtl/core/stps_checker.sv
`timescale 1ns / 1ps

module stps_checker
    import stps_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  cfg_we,
    input logic [COUNT_W-1:0]    cfg_wdata,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [S_TDATA_W-1:0]  s_tdata,
    input logic [REQ_TYPE_W-1:0] s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata
);

    // stalled result item stays offered
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result item dropped while stalled");

    // a write item never makes a result appear
    a_write_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == REQ_WRITE) && !m_tvalid |=> !m_tvalid)
        else $error("result item after write item");

    // a search item occupies the block
    a_search_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == REQ_SEARCH) |=> !s_tready)
        else $error("input taken during search");

    // a new result only comes out of a running search
    a_result_from_search: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result item without search");

endmodule

bind sorted_table_predecessor_search_top stps_checker u_stps_checker (.*);
